### src/aaf_pkg.sv
// ----------------------------------------------------------------------------
// aaf_pkg
// Shared types and constants of the AVR-style ALU and status flag unit:
// operation codes, flag positions, register file geometry, payload structs.
// ----------------------------------------------------------------------------
package aaf_pkg;

    // Operation codes carried in the func field
    typedef enum logic [4:0] {
        FN_ADD  = 5'd0,
        FN_ADC  = 5'd1,
        FN_SUB  = 5'd2,
        FN_SBC  = 5'd3,
        FN_CP   = 5'd4,
        FN_CPC  = 5'd5,
        FN_AND  = 5'd6,
        FN_OR   = 5'd7,
        FN_EOR  = 5'd8,
        FN_COM  = 5'd9,
        FN_NEG  = 5'd10,
        FN_DEC  = 5'd11,
        FN_ASR  = 5'd12,
        FN_ROR  = 5'd13,
        FN_MOV  = 5'd14,
        FN_MOVW = 5'd15,
        FN_ADIW = 5'd16,
        FN_SBIW = 5'd17
    } func_t;

    // Status register bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_V = 3;
    localparam int unsigned FLAG_S = 4;
    localparam int unsigned FLAG_H = 5;

    // Register file held as 16 rows of one register pair each
    localparam int unsigned RF_ROWS  = 16;
    localparam int unsigned ROW_W    = 16;
    localparam int unsigned ROW_AW   = $clog2(RF_ROWS);

    // Input item
    typedef struct packed {
        logic [4:0] func;
        logic [4:0] dest_reg;
        logic [4:0] src_reg;
        logic [7:0] immediate;
        logic       use_immediate;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [15:0] result_value;
        logic [7:0]  status_after;
    } out_item_t;

    // Register file write request from the execute logic
    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] row;
        logic [ROW_W-1:0]  data;
    } rf_wr_t;

endpackage

### src/aaf_ram.sv
// ----------------------------------------------------------------------------
// aaf_ram
// Generic RAM: one write port, two read ports, registered read data that
// holds while read enable is low. A read in the cycle of a write to the same
// address returns the old contents.
// ----------------------------------------------------------------------------
module aaf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### src/aaf_exec.sv
// ----------------------------------------------------------------------------
// aaf_exec
// Execute logic: byte and word arithmetic, logic, shifts and moves, new
// status flags and the register file write for one operation.
// ----------------------------------------------------------------------------
module aaf_exec
    import aaf_pkg::*;
(
    input  in_item_t        item,
    input  logic [ROW_W-1:0] a_row,   // row holding the destination register
    input  logic [ROW_W-1:0] b_row,   // row holding the source register
    input  logic [7:0]      sreg,
    output out_item_t       res,
    output rf_wr_t          wr
);

    // N, V, S and Z for a byte result
    function automatic logic [7:0] set_nvsz(logic [7:0] f, logic [7:0] xv, logic v);
        logic [7:0] r;
        r         = f;
        r[FLAG_N] = xv[7];
        r[FLAG_V] = v;
        r[FLAG_S] = xv[7] ^ v;
        r[FLAG_Z] = (xv == 8'h00);
        return r;
    endfunction

    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  x;
    logic [7:0]  vec;
    logic        cin;
    logic        nc;
    logic [15:0] xw;
    logic [15:0] k;
    logic [7:0]  flg;
    logic        byte_wr;

    // Operand selection
    assign a = item.dest_reg[0] ? a_row[15:8] : a_row[7:0];
    assign b = item.use_immediate ? item.immediate
                                  : (item.src_reg[0] ? b_row[15:8] : b_row[7:0]);
    assign k = {10'd0, item.immediate[5:0]};

    // Operation decode and flag update
    always_comb
    begin
        x       = 8'h00;
        vec     = 8'h00;
        cin     = 1'b0;
        nc      = 1'b0;
        xw      = 16'h0000;
        flg     = sreg;
        byte_wr = 1'b0;
        res.result_value = 16'h0000;
        wr.en   = 1'b0;
        wr.row  = item.dest_reg[4:1];
        wr.data = a_row;

        case (item.func)
            FN_ADD, FN_ADC:
            begin
                cin = (item.func == FN_ADC) & sreg[FLAG_C];
                x   = a + b + {7'd0, cin};
                vec = (a & b) | (b & ~x) | (~x & a);
                flg = set_nvsz(flg, x, ((a[7] & b[7] & ~x[7]) | (~a[7] & ~b[7] & x[7])));
                flg[FLAG_H] = vec[3];
                flg[FLAG_C] = vec[7];
                byte_wr = 1'b1;
            end
            FN_SUB, FN_SBC, FN_CP, FN_CPC:
            begin
                cin = ((item.func == FN_SBC) || (item.func == FN_CPC)) & sreg[FLAG_C];
                x   = a - b - {7'd0, cin};
                vec = (~a & b) | (b & x) | (x & ~a);
                flg = set_nvsz(flg, x, ((a[7] & ~b[7] & ~x[7]) | (~a[7] & b[7] & x[7])));
                // carry-chained forms keep Z only through a zero result
                if ((item.func == FN_SBC) || (item.func == FN_CPC))
                begin
                    flg[FLAG_Z] = sreg[FLAG_Z] & (x == 8'h00);
                end
                flg[FLAG_H] = vec[3];
                flg[FLAG_C] = vec[7];
                byte_wr = (item.func == FN_SUB) || (item.func == FN_SBC);
            end
            FN_AND, FN_OR, FN_EOR:
            begin
                if (item.func == FN_AND)
                begin
                    x = a & b;
                end
                else if (item.func == FN_OR)
                begin
                    x = a | b;
                end
                else
                begin
                    x = a ^ b;
                end
                flg = set_nvsz(flg, x, 1'b0);
                byte_wr = 1'b1;
            end
            FN_COM:
            begin
                x   = ~a;
                flg = set_nvsz(flg, x, 1'b0);
                flg[FLAG_C] = 1'b1;
                byte_wr = 1'b1;
            end
            FN_NEG:
            begin
                x   = 8'h00 - a;
                flg = set_nvsz(flg, x, (x == 8'h80));
                flg[FLAG_H] = x[3] | a[3];
                flg[FLAG_C] = (x != 8'h00);
                byte_wr = 1'b1;
            end
            FN_DEC:
            begin
                x   = a - 8'h01;
                flg = set_nvsz(flg, x, (x == 8'h7f));
                byte_wr = 1'b1;
            end
            FN_ASR, FN_ROR:
            begin
                nc  = a[0];
                x   = {((item.func == FN_ASR) ? a[7] : sreg[FLAG_C]), a[7:1]};
                flg = set_nvsz(flg, x, x[7] ^ nc);
                flg[FLAG_C] = nc;
                byte_wr = 1'b1;
            end
            FN_MOV:
            begin
                x       = b;
                byte_wr = 1'b1;
            end
            FN_MOVW:
            begin
                res.result_value = b_row;
                wr.en   = 1'b1;
                wr.data = b_row;
            end
            FN_ADIW, FN_SBIW:
            begin
                if (item.func == FN_ADIW)
                begin
                    xw = a_row + k;
                    flg[FLAG_V] = ~a_row[15] & xw[15];
                    flg[FLAG_C] = ~xw[15] & a_row[15];
                end
                else
                begin
                    xw = a_row - k;
                    flg[FLAG_V] = a_row[15] & ~xw[15];
                    flg[FLAG_C] = xw[15] & ~a_row[15];
                end
                flg[FLAG_N] = xw[15];
                flg[FLAG_S] = xw[15] ^ flg[FLAG_V];
                flg[FLAG_Z] = (xw == 16'h0000);
                res.result_value = xw;
                wr.en   = 1'b1;
                wr.data = xw;
            end
            default:
            begin
                // unknown code: no state change
                flg = sreg;
            end
        endcase

        // byte results merge into their half of the pair row
        if ((item.func != FN_MOVW) && (item.func != FN_ADIW) && (item.func != FN_SBIW)
            && (item.func <= FN_SBIW))
        begin
            res.result_value = {8'h00, x};
        end
        if (byte_wr)
        begin
            wr.en   = 1'b1;
            wr.data = item.dest_reg[0] ? {x, a_row[7:0]} : {a_row[15:8], x};
        end
        res.status_after = flg;
    end

endmodule

### src/avr_alu_flag_unit.sv
// ----------------------------------------------------------------------------
// avr_alu_flag_unit
// Execute unit of an 8-bit AVR-style core: register file of 32 bytes, status
// register, byte and word ALU operations with one result per operation.
//
//   Channel   Signals                              Direction
//   item      item_valid, item_stall, item         operation in
//   result    result_valid, result_stall, result   value and flags out
//
// Two register stages: the stage register (with register file read), then the
// result register. One operation per cycle sustained while the result is not
// stalled, set by the single pass through the execute logic between the stage
// register and the result register.
// The register file is a two-read RAM of 16 pair rows; the last write is
// forwarded to the next operation. Reset clears the status register and the
// row valid bits at once, so every register reads zero; no clearing pass.
// A stalled result holds; item_stall rises only when the stage is also full.
// ----------------------------------------------------------------------------
module avr_alu_flag_unit
    import aaf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic [RF_ROWS-1:0] row_valid_reg;
    logic              lw_valid_reg;
    logic [ROW_AW-1:0] lw_row_reg;
    logic [ROW_W-1:0]  lw_data_reg;
    logic [7:0]        sreg_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    logic              accept;
    logic              s1_fire;
    logic [ROW_W-1:0]  ram_a;
    logic [ROW_W-1:0]  ram_b;
    logic [ROW_W-1:0]  a_row;
    logic [ROW_W-1:0]  b_row;
    logic [ROW_AW-1:0] a_addr;
    logic [ROW_AW-1:0] b_addr;
    out_item_t         ex_res;
    rf_wr_t            ex_wr;

    // Handshake
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_fire;
    assign accept     = item_valid && !item_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // Register file, read on transfer
    aaf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (RF_ROWS)
    ) u_rf (
        .clk       (clk),
        .wr_en     (s1_fire && ex_wr.en),
        .wr_addr   (ex_wr.row),
        .wr_data   (ex_wr.data),
        .rd_en     (accept),
        .rd_addr_a (item.dest_reg[4:1]),
        .rd_addr_b (item.src_reg[4:1]),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    // Forward last write, rows never written read as zero
    assign a_addr = s1_item_reg.dest_reg[4:1];
    assign b_addr = s1_item_reg.src_reg[4:1];

    always_comb
    begin
        if (lw_valid_reg && (lw_row_reg == a_addr))
        begin
            a_row = lw_data_reg;
        end
        else if (row_valid_reg[a_addr])
        begin
            a_row = ram_a;
        end
        else
        begin
            a_row = '0;
        end

        if (lw_valid_reg && (lw_row_reg == b_addr))
        begin
            b_row = lw_data_reg;
        end
        else if (row_valid_reg[b_addr])
        begin
            b_row = ram_b;
        end
        else
        begin
            b_row = '0;
        end
    end

    aaf_exec u_exec (
        .item  (s1_item_reg),
        .a_row (a_row),
        .b_row (b_row),
        .sreg  (sreg_reg),
        .res   (ex_res),
        .wr    (ex_wr)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            lw_valid_reg  <= 1'b0;
            sreg_reg      <= 8'h00;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                sreg_reg      <= ex_res.status_after;
                if (ex_wr.en)
                begin
                    row_valid_reg[ex_wr.row] <= 1'b1;
                    lw_valid_reg             <= 1'b1;
                end
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (s1_fire)
        begin
            out_item_reg <= ex_res;
            if (ex_wr.en)
            begin
                lw_row_reg  <= ex_wr.row;
                lw_data_reg <= ex_wr.data;
            end
        end
    end

endmodule
